/* src/zts_pkg.sv */
// package: types, constants and key-schedule functions for the zip stream cipher
package zts_pkg;

    localparam logic [31:0] KEY_CRC_FIRST_INIT  = 32'd305419896;
    localparam logic [31:0] KEY_LCG_INIT        = 32'd591751049;
    localparam logic [31:0] KEY_CRC_SECOND_INIT = 32'd878082192;
    localparam logic [31:0] LCG_MULT            = 32'd134775813;
    localparam logic [31:0] CRC_POLY            = 32'hEDB88320;

    typedef enum logic [1:0] {
        ACT_RESTART  = 2'd0,
        ACT_PASSWORD = 2'd1,
        ACT_ENCRYPT  = 2'd2,
        ACT_DECRYPT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2
    } state_t;

    typedef struct packed {
        logic load_item;
        logic restart;
        logic fold_first;
        logic emit;
        logic fold_second;
    } cmd_t;

    typedef struct packed {
        action_t action;
    } status_t;

    // raw reflected crc-32 byte step, no inversion
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] stream_byte(input logic [31:0] key);
        logic [15:0] t;
        logic [31:0] prod;
        t    = key[15:0] | 16'h0002;
        prod = 32'(t) * 32'(t ^ 16'h0001);
        return prod[15:8];
    endfunction

endpackage

/* src/zts_in_if.sv */
// interface: input item channel
interface zts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* src/zts_out_if.sv */
// interface: result item channel
interface zts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       check_match;

    modport source (output valid, output out_byte, output check_match, input ready);
    modport sink   (input valid, input out_byte, input check_match, output ready);
endinterface

/* src/zts_cfg_if.sv */
// interface: check byte write channel
interface zts_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] check_byte;

    modport source (output valid, output check_byte, input ready);
    modport sink   (input valid, input check_byte, output ready);
endinterface

/* src/zts_ctrl.sv */
// controller: sequencing of the two key-update steps and the result buffer
module zts_ctrl
    import zts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   out_free;
    logic   need_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE) || (state_reg == S_STEP2);
        in_fire     = in_valid && in_ready;
        out_free    = !out_valid_reg || out_ready;
        need_result = status.action inside {ACT_ENCRYPT, ACT_DECRYPT};
        cmd         = '0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_STEP1;
                end
            end
            S_STEP1:
            begin
                if (status.action == ACT_RESTART)
                begin
                    cmd.restart = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!need_result || out_free)
                begin
                    cmd.fold_first = 1'b1;
                    cmd.emit       = need_result;
                    state_next     = S_STEP2;
                end
            end
            S_STEP2:
            begin
                cmd.fold_second = 1'b1;
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_STEP1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_valid      = out_valid_reg;
    end

    // an accepted item always starts its first step next
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> state_reg == S_STEP1)
        else $error("accepted item did not enter first step");

    // a result is never written over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> out_free)
        else $error("result buffer overwritten");

    // a new result only appears after a first step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_STEP1))
        else $error("result raised outside first step");

endmodule

/* src/zts_datapath.sv */
// datapath: key registers, keystream byte, item latch, check byte and result buffer
module zts_datapath
    import zts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_check_byte,
    input  logic [1:0] in_action,
    input  logic [7:0] in_data_byte,
    input  cmd_t       cmd,
    output status_t    status,
    output logic [7:0] out_byte,
    output logic       check_match
);

    logic [31:0] key_crc_first_reg;
    logic [31:0] key_lcg_reg;
    logic [31:0] key_crc_second_reg;
    logic [7:0]  ks_reg;
    logic [7:0]  check_reg;
    action_t     action_reg;
    logic [7:0]  data_reg;
    logic [7:0]  out_byte_reg;
    logic        match_reg;

    logic [7:0]  res_byte;
    logic [7:0]  plain_byte;
    logic [31:0] crc_first_next;
    logic [31:0] lcg_sum;
    logic [31:0] lcg_next;
    logic [31:0] crc_second_next;

    always_comb
    begin
        res_byte        = data_reg ^ ks_reg;
        plain_byte      = (action_reg == ACT_DECRYPT) ? res_byte : data_reg;
        crc_first_next  = crc_step(key_crc_first_reg, plain_byte);
        lcg_sum         = key_lcg_reg + {24'd0, crc_first_next[7:0]};
        lcg_next        = 32'(lcg_sum * LCG_MULT) + 32'd1;
        crc_second_next = crc_step(key_crc_second_reg, key_lcg_reg[31:24]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_crc_first_reg  <= KEY_CRC_FIRST_INIT;
            key_lcg_reg        <= KEY_LCG_INIT;
            key_crc_second_reg <= KEY_CRC_SECOND_INIT;
            ks_reg             <= stream_byte(KEY_CRC_SECOND_INIT);
            check_reg          <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                check_reg <= cfg_check_byte;
            end
            if (cmd.restart)
            begin
                key_crc_first_reg  <= KEY_CRC_FIRST_INIT;
                key_lcg_reg        <= KEY_LCG_INIT;
                key_crc_second_reg <= KEY_CRC_SECOND_INIT;
                ks_reg             <= stream_byte(KEY_CRC_SECOND_INIT);
            end
            if (cmd.fold_first)
            begin
                key_crc_first_reg <= crc_first_next;
                key_lcg_reg       <= lcg_next;
            end
            if (cmd.fold_second)
            begin
                key_crc_second_reg <= crc_second_next;
                ks_reg             <= stream_byte(crc_second_next);
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action_t'(in_action);
            data_reg   <= in_data_byte;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= res_byte;
            match_reg    <= (plain_byte == check_reg);
        end
    end

    assign status.action = action_reg;
    assign out_byte      = out_byte_reg;
    assign check_match   = match_reg;

endmodule

/* src/zip_traditional_stream_cipher_unit.sv */
// top level: traditional zip stream cipher engine, one byte per item
//
//  channel  | direction | payload                      | transfer when
//  ---------+-----------+------------------------------+------------------------
//  in_ch    | sink      | action[1:0], data_byte[7:0]  | in_ch.valid && ready
//  out_ch   | source    | out_byte[7:0], check_match   | out_ch.valid && ready
//  cfg_ch   | sink      | check_byte[7:0]              | cfg_ch.valid (ready high)
//
// for each item the first step folds the plaintext into the crc and lcg keys
// (crc byte step, add, 32x32 multiply), the second updates the second crc key and the
// registered keystream byte (crc step, 16x16 multiply); a restart reloads the keys in
// its one step and drops back to idle; the input is ready in idle and during the second
// step, so a new item can be taken while the last finishes its second step; it is never
// ready during a first step
// after reset the keys hold their fixed initial values and check_byte is zero
// a full result buffer stalls an encrypt or decrypt item in its first step, which holds
// the input off until the waiting result transfers; the check byte can be written at any
// time the block is idle
module zip_traditional_stream_cipher_unit
    import zts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    zts_in_if.sink  in_ch,
    zts_out_if.source out_ch,
    zts_cfg_if.sink cfg_ch
);

    cmd_t    cmd;
    status_t status;

    // the check byte register accepts every write
    assign cfg_ch.ready = 1'b1;

    // sequencing: accept, first step, second step
    zts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // keys, keystream and result payload
    zts_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_ch.valid),
        .cfg_check_byte (cfg_ch.check_byte),
        .in_action      (in_ch.action),
        .in_data_byte   (in_ch.data_byte),
        .cmd            (cmd),
        .status         (status),
        .out_byte       (out_ch.out_byte),
        .check_match    (out_ch.check_match)
    );

endmodule

/* sim/zts_result_checker.sv */
// result checker: predicts every cipher result from the observed transfers and compares
module zts_result_checker
    import zts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    zts_in_if   in_ch,
    zts_out_if  out_ch,
    zts_cfg_if  cfg_ch,
    output int  mismatches,
    output int  open_results
);

    typedef struct packed {
        logic [7:0] text;
        logic       hit;
    } cipher_result_t;

    cipher_result_t result_fifo [$];
    cipher_result_t oldest;

    // predicted key state and check byte
    logic [31:0] crc_a;
    logic [31:0] mul_key;
    logic [31:0] crc_b;
    logic [7:0]  check_value;

    action_t     seen_action;
    logic [7:0]  in_byte;
    logic [7:0]  pad;
    logic [7:0]  res_byte;
    logic [7:0]  plain_byte;
    int          results_checked;

    // reflected crc-32 over one byte, no inversion
    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8)
        begin
            r = {1'b0, r[31:1]} ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    function automatic logic [7:0] pad_byte(input logic [31:0] k);
        logic [15:0] t;
        logic [31:0] prod;
        t    = k[15:0] | 16'h0002;
        prod = {16'd0, t} * {16'd0, t ^ 16'h0001};
        return prod[15:8];
    endfunction

    task automatic fold_plain(input logic [7:0] p);
        crc_a   = crc_fold(crc_a, p);
        mul_key = (mul_key + {24'd0, crc_a[7:0]}) * LCG_MULT + 32'd1;
        crc_b   = crc_fold(crc_b, mul_key[31:24]);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("result check: %s got %h want %h at result %0d",
                     what, got, want, results_checked);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_a       = KEY_CRC_FIRST_INIT;
            mul_key     = KEY_LCG_INIT;
            crc_b       = KEY_CRC_SECOND_INIT;
            check_value = 8'h00;
            result_fifo.delete();
        end
        else
        begin
            // compare first, so a result never meets an item taken at the same edge
            if (out_ch.valid && out_ch.ready)
            begin
                results_checked++;
                if (result_fifo.size() == 0)
                begin
                    report_mismatch("unexpected result", out_ch.out_byte, 8'h00);
                end
                else
                begin
                    oldest = result_fifo.pop_front();
                    if (out_ch.out_byte !== oldest.text)
                        report_mismatch("out_byte", out_ch.out_byte, oldest.text);
                    if (out_ch.check_match !== oldest.hit)
                        report_mismatch("check_match", {7'd0, out_ch.check_match},
                                        {7'd0, oldest.hit});
                end
            end

            if (cfg_ch.valid && cfg_ch.ready)
                check_value = cfg_ch.check_byte;

            if (in_ch.valid && in_ch.ready)
            begin
                seen_action = action_t'(in_ch.action);
                in_byte     = in_ch.data_byte;
                case (seen_action)
                    ACT_RESTART:
                    begin
                        crc_a   = KEY_CRC_FIRST_INIT;
                        mul_key = KEY_LCG_INIT;
                        crc_b   = KEY_CRC_SECOND_INIT;
                    end
                    ACT_PASSWORD:
                    begin
                        fold_plain(in_byte);
                    end
                    default:
                    begin
                        pad        = pad_byte(crc_b);
                        res_byte   = in_byte ^ pad;
                        plain_byte = (seen_action == ACT_ENCRYPT) ? in_byte : res_byte;
                        fold_plain(plain_byte);
                        result_fifo.push_back('{text: res_byte, hit: (plain_byte == check_value)});
                    end
                endcase
            end
        end
        open_results = result_fifo.size();
    end

endmodule

/* sim/tb_top.sv */
// testbench top: stimulus, output stalls and verdict for the zip stream cipher unit
module tb_top
    import zts_pkg::*;
;

    // run shape
    localparam int ITEM_TARGET    = 1120;    // directed plus random items offered
    localparam int SETTLE_CYCLES  = 8;       // a restart or password byte may still be in flight
    localparam int HOLD_CYCLES    = 300;     // long output stall, fills the block
    localparam int PRESSURE_ROUND = 5;
    localparam int CYCLE_LIMIT    = 600000;

    logic clk;
    logic rst_n;

    zts_in_if  in_ch ();
    zts_out_if out_ch ();
    zts_cfg_if cfg_ch ();

    zip_traditional_stream_cipher_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    int check_fails;
    int check_open;

    zts_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .mismatches   (check_fails),
        .open_results (check_open)
    );

    // bookkeeping shared by the sender and the receiver
    int         items_sent;
    int         results_wanted;
    int         results_got;
    int         matches_seen;
    int         check_writes;
    int         action_count [4];
    int         cycle_count;
    logic [7:0] cur_check;
    logic [7:0] cipher_log [$];     // every out_byte in arrival order
    bit         tx_calm;            // sender offers back to back when set
    bit         hold_req;           // asks the receiver for its long stall

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a lost result or a stuck handshake ends up here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("zip_traditional_stream_cipher_unit: mismatch");
        $finish;
    end

    // one input transfer, preceded by a random gap; valid stays high afterwards so a
    // following item can go back to back, callers that pause must drop it first
    task automatic send_item(input action_t act, input logic [7:0] b);
        int gap;
        int pick;
        pick = $urandom_range(99);
        if (tx_calm || pick < 55)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(15, 50);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        action_count[act]++;
        if (act == ACT_ENCRYPT || act == ACT_DECRYPT)
            results_wanted++;
    endtask

    // stop offering, let every result drain, then give a trailing restart or
    // password byte time to finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        wait (results_got == results_wanted);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // check byte write, only ever issued from an idle block
    task automatic write_check(input logic [7:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.check_byte <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_check = v;
        check_writes++;
    endtask

    // receiver: logs every result transfer and shapes ready in runs of random length
    initial
    begin
        int   run_left;
        int   pick;
        logic lvl;
        run_left = 0;
        lvl      = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                cipher_log.push_back(out_ch.out_byte);
                results_got++;
                if (out_ch.check_match)
                    matches_seen++;
            end
            if (hold_req)
            begin
                // long stall, counted here while the sender keeps offering
                hold_req = 1'b0;
                lvl      = 1'b0;
                run_left = HOLD_CYCLES;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    lvl      = 1'b1;
                    run_left = $urandom_range(1, 30);
                end
                else if (pick < 55)
                begin
                    // a stretch with no stalls at all
                    lvl      = 1'b1;
                    run_left = $urandom_range(100, 200);
                end
                else if (pick < 85)
                begin
                    lvl      = 1'b0;
                    run_left = $urandom_range(1, 3);
                end
                else if (pick < 97)
                begin
                    lvl      = 1'b0;
                    run_left = $urandom_range(4, 12);
                end
                else
                begin
                    lvl      = 1'b0;
                    run_left = $urandom_range(20, 60);
                end
            end
            out_ch.ready <= lvl;
        end
    end

    // sender: reset, directed items, then rounds of random traffic
    initial
    begin
        logic [7:0] password [$];
        logic [7:0] plaintext [$];
        logic [7:0] ciphertext [$];
        int         round;
        int         pick;
        int         pw_len;
        int         body_len;
        int         n;

        tx_calm  = 1'b0;
        hold_req = 1'b0;
        cur_check = 8'h00;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_RESTART;
        in_ch.data_byte   <= 8'h00;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.check_byte <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every action, keys straight out of reset
        write_check(8'hFF);
        send_item(ACT_ENCRYPT, 8'h00);          // reset keys with no restart first
        send_item(ACT_ENCRYPT, 8'hFF);          // plaintext equal to the check byte
        send_item(ACT_DECRYPT, 8'h00);
        send_item(ACT_DECRYPT, 8'hFF);
        send_item(ACT_PASSWORD, 8'h00);         // no result, keys move on
        send_item(ACT_PASSWORD, 8'hFF);
        send_item(ACT_RESTART, 8'hFF);          // data ignored on a restart
        send_item(ACT_RESTART, 8'h00);          // back to back restarts
        send_item(ACT_ENCRYPT, 8'hA5);
        send_item(ACT_PASSWORD, 8'h5A);
        send_item(ACT_DECRYPT, 8'h5A);
        send_item(ACT_DECRYPT, 8'hA5);
        wait_idle();
        write_check(8'h00);
        send_item(ACT_RESTART, 8'h00);          // restart keeps the check byte
        send_item(ACT_ENCRYPT, 8'h00);
        send_item(ACT_ENCRYPT, 8'h80);
        send_item(ACT_DECRYPT, 8'h01);
        send_item(ACT_PASSWORD, 8'h7F);
        send_item(ACT_RESTART, 8'h00);
        send_item(ACT_DECRYPT, 8'h00);
        wait_idle();

        // random rounds; the check byte moves every fourth round
        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (round % 4 == 0)
            begin
                wait_idle();
                case ((round / 4) % 4)
                    0:       write_check(8'h00);
                    1:       write_check(8'hFF);
                    default: write_check(8'($urandom_range(255)));
                endcase
            end
            tx_calm = ($urandom_range(3) == 0) || (round == PRESSURE_ROUND);
            pick    = $urandom_range(99);

            if (pick < 70 || round == PRESSURE_ROUND)
            begin
                // well-formed: encrypt a 12-byte header whose last byte is the check
                // byte plus a body, then decrypt what came out under the same password
                password.delete();
                plaintext.delete();
                pw_len = $urandom_range(1, 8);
                repeat (pw_len) password.push_back(8'($urandom_range(255)));
                repeat (11) plaintext.push_back(8'($urandom_range(255)));
                plaintext.push_back(cur_check);
                if (round == PRESSURE_ROUND)
                    body_len = 60;
                else if ($urandom_range(9) == 0)
                    body_len = $urandom_range(25, 60);
                else
                    body_len = $urandom_range(0, 24);
                repeat (body_len)
                begin
                    plaintext.push_back(($urandom_range(9) == 0) ? cur_check
                                                                 : 8'($urandom_range(255)));
                end

                wait_idle();
                cipher_log.delete();
                send_item(ACT_RESTART, 8'($urandom_range(255)));
                foreach (password[i])
                    send_item(ACT_PASSWORD, password[i]);
                if (round == PRESSURE_ROUND)
                    hold_req = 1'b1;
                foreach (plaintext[i])
                    send_item(ACT_ENCRYPT, plaintext[i]);
                wait_idle();
                ciphertext = cipher_log;

                // now and then a wrong password, so the header check fails
                if ($urandom_range(4) == 0)
                    password[$urandom_range(password.size() - 1)] ^= 8'($urandom_range(1, 255));
                send_item(ACT_RESTART, 8'($urandom_range(255)));
                foreach (password[i])
                    send_item(ACT_PASSWORD, password[i]);
                foreach (ciphertext[i])
                    send_item(ACT_DECRYPT, ciphertext[i]);
            end
            else if (pick < 88)
            begin
                // noise: any action with any byte, keys carried over
                n = $urandom_range(10, 40);
                repeat (n) send_item(action_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
            else
            begin
                // broken sequence: header cut short by a restart, then stray ciphertext
                send_item(ACT_RESTART, 8'($urandom_range(255)));
                n = $urandom_range(1, 3);
                repeat (n) send_item(ACT_PASSWORD, 8'($urandom_range(255)));
                n = $urandom_range(1, 11);
                repeat (n) send_item(ACT_ENCRYPT, 8'($urandom_range(255)));
                send_item(ACT_RESTART, 8'($urandom_range(255)));
                n = $urandom_range(1, 12);
                repeat (n) send_item(ACT_DECRYPT, 8'($urandom_range(255)));
            end
            round++;
        end
        wait_idle();

        $display("run covered %0d items: %0d restart, %0d password, %0d encrypt, %0d decrypt",
                 items_sent, action_count[ACT_RESTART], action_count[ACT_PASSWORD],
                 action_count[ACT_ENCRYPT], action_count[ACT_DECRYPT]);
        $display("%0d results, %0d check byte hits, %0d check byte writes, %0d-cycle output stall",
                 results_got, matches_seen, check_writes, HOLD_CYCLES);
        if (check_fails == 0 && check_open == 0)
            $display("zip_traditional_stream_cipher_unit: match");
        else
            $display("zip_traditional_stream_cipher_unit: mismatch");
        $finish;
    end

endmodule

/* zip_traditional_stream_cipher_unit.f */
src/zts_pkg.sv
src/zts_in_if.sv
src/zts_out_if.sv
src/zts_cfg_if.sv
src/zts_ctrl.sv
src/zts_datapath.sv
src/zip_traditional_stream_cipher_unit.sv
sim/zts_result_checker.sv
sim/tb_top.sv
